[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CPVP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cpvp_pkg.sv]
package cpvp_pkg;

    localparam int unsigned FORCE_FIELDS = 3;
    localparam int unsigned GAIN_W       = 24;
    localparam int unsigned LIM_W        = 31;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned OPND_W       = 33;
    localparam int unsigned PROD_W       = GAIN_W + 1 + OPND_W;
    localparam int unsigned FRAC_W       = 16;
    localparam int unsigned PQ_W         = PROD_W - FRAC_W;
    localparam int unsigned ADDR_W       = 5;

    typedef enum logic [2:0] {
        REG_POS_GAIN  = 3'd0,
        REG_VEL_PGAIN = 3'd1,
        REG_VEL_IGAIN = 3'd2,
        REG_VEL_DGAIN = 3'd3,
        REG_INT_LIM   = 3'd4,
        REG_MASS      = 3'd5,
        REG_GRAVITY   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]        pos_gain;
        logic [GAIN_W-1:0]        vel_pgain;
        logic [GAIN_W-1:0]        vel_igain;
        logic [GAIN_W-1:0]        vel_dgain;
        logic [LIM_W-1:0]         int_lim;
        logic [GAIN_W-1:0]        mass;
        logic signed [DATA_W-1:0] gravity;
    } t_cfg;

endpackage

[sv/cpvp_mul.sv]
// Shared multiplier: unsigned gain times signed operand, product registered.
module cpvp_mul (
    input  logic                                 i_clk,
    input  logic [cpvp_pkg::GAIN_W-1:0]          i_gain,
    input  logic signed [cpvp_pkg::OPND_W-1:0]   i_opnd,
    output logic signed [cpvp_pkg::PROD_W-1:0]   o_prod
);

    logic signed [cpvp_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, i_gain}) * i_opnd;
    end

    assign o_prod = r_prod;

endmodule

[sv/cpvp_regs.sv]
module cpvp_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cpvp_pkg::ADDR_W-1:0]       paddr,
    input  logic [cpvp_pkg::DATA_W-1:0]       pwdata,
    output logic [cpvp_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    output cpvp_pkg::t_cfg                    o_cfg
);

    cpvp_pkg::t_cfg r_cfg;
    cpvp_pkg::t_reg_idx w_idx;
    logic w_wr;

    assign w_idx  = cpvp_pkg::t_reg_idx'(paddr[cpvp_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_gain  <= 24'd65536;
            r_cfg.vel_pgain <= 24'd65536;
            r_cfg.vel_igain <= '0;
            r_cfg.vel_dgain <= '0;
            r_cfg.int_lim   <= 31'd65536;
            r_cfg.mass      <= 24'd65536;
            r_cfg.gravity   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                cpvp_pkg::REG_POS_GAIN:  r_cfg.pos_gain  <= pwdata[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_VEL_PGAIN: r_cfg.vel_pgain <= pwdata[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_VEL_IGAIN: r_cfg.vel_igain <= pwdata[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_VEL_DGAIN: r_cfg.vel_dgain <= pwdata[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_INT_LIM:   r_cfg.int_lim   <= pwdata[cpvp_pkg::LIM_W-1:0];
                cpvp_pkg::REG_MASS:      r_cfg.mass      <= pwdata[cpvp_pkg::GAIN_W-1:0];
                cpvp_pkg::REG_GRAVITY:   r_cfg.gravity   <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            cpvp_pkg::REG_POS_GAIN:  prdata = {8'd0, r_cfg.pos_gain};
            cpvp_pkg::REG_VEL_PGAIN: prdata = {8'd0, r_cfg.vel_pgain};
            cpvp_pkg::REG_VEL_IGAIN: prdata = {8'd0, r_cfg.vel_igain};
            cpvp_pkg::REG_VEL_DGAIN: prdata = {8'd0, r_cfg.vel_dgain};
            cpvp_pkg::REG_INT_LIM:   prdata = {1'b0, r_cfg.int_lim};
            cpvp_pkg::REG_MASS:      prdata = {8'd0, r_cfg.mass};
            cpvp_pkg::REG_GRAVITY:   prdata = r_cfg.gravity;
            default:                 prdata = '0;
        endcase
    end

endmodule

[sv/cascaded_position_velocity_pid.sv]
// Channel  | Direction | Handshake                | Word
// ---------+-----------+--------------------------+------------------------------------
// in       | to block  | i_in_valid / o_in_stall  | pos, vel, target x/y/z, autonomous, armed
// out      | from block| o_out_valid / i_out_stall| force x/y/z, active
// apb      | to block  | psel/penable/pready      | seven control registers at 4*index
//
// An armed word works through the axes in turn on one shared 24x33 multiplier, between
// the accept step and the hand-off step.
// A disarmed word skips straight to hand-off and leaves the controller state untouched.
// Reset is synchronous, active low; integrator and previous velocity clear to zero.
// A finished word waits in the output register; the next word may be accepted and
// worked on meanwhile, and the sequencer holds at hand-off until that register frees.
`include "assert_macros.svh"

module cascaded_position_velocity_pid #(
    parameter int unsigned AXES = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_current_pos_x,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_current_pos_y,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_current_pos_z,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_current_vel_x,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_current_vel_y,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_current_vel_z,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_target_pos_x,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_target_pos_y,
    input  logic signed [cpvp_pkg::DATA_W-1:0]   i_target_pos_z,
    input  logic                                 i_autonomous,
    input  logic                                 i_armed,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [cpvp_pkg::DATA_W-1:0]   o_force_x,
    output logic signed [cpvp_pkg::DATA_W-1:0]   o_force_y,
    output logic signed [cpvp_pkg::DATA_W-1:0]   o_force_z,
    output logic                                 o_active,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cpvp_pkg::ADDR_W-1:0]          paddr,
    input  logic [cpvp_pkg::DATA_W-1:0]          pwdata,
    output logic [cpvp_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int unsigned AW     = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int unsigned NF     = cpvp_pkg::FORCE_FIELDS;
    localparam int unsigned DW     = cpvp_pkg::DATA_W;
    localparam int unsigned OW     = cpvp_pkg::OPND_W;
    localparam int unsigned PQW    = cpvp_pkg::PQ_W;
    localparam int unsigned IW     = PQW + 1;
    localparam int unsigned SW     = PQW + 3;
    localparam logic [AW-1:0] LAST_AXIS = AW'(AXES - 1);

    localparam logic signed [PQW-1:0] VSP_MAX = PQW'(32768);
    localparam logic signed [PQW-1:0] VSP_MIN = -PQW'(32768);
    localparam logic signed [SW-1:0]  S32_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0]  S32_MIN = -SW'(64'sd2147483648);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_MVSP, S_VSP, S_MINT, S_INT, S_MPRP,
        S_DV, S_MDRV, S_SUM, S_MMAS, S_FRC, S_DONE
    } t_state;

    cpvp_pkg::t_cfg w_cfg;

    t_state                  r_state;
    logic [AW-1:0]           r_axis;
    logic                    r_auto;
    logic                    r_act;
    logic signed [DW-1:0]    r_pos   [NF];
    logic signed [DW-1:0]    r_vel   [NF];
    logic signed [DW-1:0]    r_tgt   [NF];
    logic signed [DW-1:0]    r_force [NF];
    logic signed [DW-1:0]    r_integ_st [AXES];
    logic signed [DW-1:0]    r_prev_st  [AXES];
    logic signed [OW-1:0]    r_a;
    logic signed [OW-1:0]    r_verr;
    logic signed [DW-1:0]    r_integ;
    logic signed [SW-1:0]    r_sum;
    logic                    r_ovalid;
    logic                    r_oact;
    logic signed [DW-1:0]    r_ofx;
    logic signed [DW-1:0]    r_ofy;
    logic signed [DW-1:0]    r_ofz;

    logic [cpvp_pkg::GAIN_W-1:0]          w_gain;
    logic signed [OW-1:0]                 w_opnd;
    logic signed [cpvp_pkg::PROD_W-1:0]   w_prod;
    logic signed [PQW-1:0]                w_pq;
    logic signed [DW-1:0]                 w_vel;
    logic signed [PQW-1:0]                w_vsp;
    logic signed [IW-1:0]                 w_isum;
    logic signed [IW-1:0]                 w_lim;
    logic signed [IW-1:0]                 w_iclmp;
    logic signed [SW-1:0]                 w_s;
    logic signed [SW-1:0]                 w_sclmp;
    logic signed [SW-1:0]                 w_f;
    logic signed [SW-1:0]                 w_fclmp;
    logic                                 w_accept;
    logic                                 w_load;

    cpvp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cpvp_mul u_mul (
        .i_clk  (i_clk),
        .i_gain (w_gain),
        .i_opnd (w_opnd),
        .o_prod (w_prod)
    );

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_MVSP: begin
                w_gain = w_cfg.pos_gain;
                w_opnd = r_a;
            end
            S_MINT: begin
                w_gain = w_cfg.vel_igain;
                w_opnd = r_verr;
            end
            S_MPRP: begin
                w_gain = w_cfg.vel_pgain;
                w_opnd = r_verr;
            end
            S_MDRV: begin
                w_gain = w_cfg.vel_dgain;
                w_opnd = r_a;
            end
            S_MMAS: begin
                w_gain = w_cfg.mass;
                w_opnd = r_a;
            end
            default: begin
                w_gain = '0;
                w_opnd = '0;
            end
        endcase
    end

    // floor(product / 2^16) is an arithmetic right shift
    assign w_pq  = w_prod[cpvp_pkg::PROD_W-1:cpvp_pkg::FRAC_W];
    assign w_vel = r_vel[r_axis];

    always_comb begin
        if (w_pq > VSP_MAX) begin
            w_vsp = VSP_MAX;
        end else if (w_pq < VSP_MIN) begin
            w_vsp = VSP_MIN;
        end else begin
            w_vsp = w_pq;
        end
    end

    assign w_lim  = $signed({{(IW - cpvp_pkg::LIM_W){1'b0}}, w_cfg.int_lim});
    assign w_isum = r_auto ? (IW'(r_integ_st[r_axis]) + IW'(w_pq)) : '0;

    always_comb begin
        if (w_isum > w_lim) begin
            w_iclmp = w_lim;
        end else if (w_isum < -w_lim) begin
            w_iclmp = -w_lim;
        end else begin
            w_iclmp = w_isum;
        end
    end

    assign w_s = r_sum - SW'(w_pq);

    always_comb begin
        if (w_s > S32_MAX) begin
            w_sclmp = S32_MAX;
        end else if (w_s < S32_MIN) begin
            w_sclmp = S32_MIN;
        end else begin
            w_sclmp = w_s;
        end
    end

    // gravity lands on the x axis only
    assign w_f = SW'(w_pq) + ((r_axis == '0) ? SW'(w_cfg.gravity) : '0);

    always_comb begin
        if (w_f > S32_MAX) begin
            w_fclmp = S32_MAX;
        end else if (w_f < S32_MIN) begin
            w_fclmp = S32_MIN;
        end else begin
            w_fclmp = w_f;
        end
    end

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_integ_st[k] <= '0;
                r_prev_st[k]  <= '0;
            end
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pos[0] <= i_current_pos_x;
                        r_pos[1] <= i_current_pos_y;
                        r_pos[2] <= i_current_pos_z;
                        r_vel[0] <= i_current_vel_x;
                        r_vel[1] <= i_current_vel_y;
                        r_vel[2] <= i_current_vel_z;
                        r_tgt[0] <= i_target_pos_x;
                        r_tgt[1] <= i_target_pos_y;
                        r_tgt[2] <= i_target_pos_z;
                        r_auto   <= i_autonomous;
                        r_act    <= i_armed;
                        r_axis   <= '0;
                        for (int k = 0; k < NF; k++) begin
                            r_force[k] <= '0;
                        end
                        r_state  <= i_armed ? S_ERR : S_DONE;
                    end
                end
                S_ERR: begin
                    r_a     <= OW'(r_tgt[r_axis]) - OW'(r_pos[r_axis]);
                    r_state <= S_MVSP;
                end
                S_MVSP: r_state <= S_VSP;
                S_VSP: begin
                    r_verr  <= OW'(w_vsp) - OW'(w_vel);
                    r_state <= S_MINT;
                end
                S_MINT: r_state <= S_INT;
                S_INT: begin
                    r_integ            <= w_iclmp[DW-1:0];
                    r_integ_st[r_axis] <= w_iclmp[DW-1:0];
                    r_state            <= S_MPRP;
                end
                S_MPRP: r_state <= S_DV;
                S_DV: begin
                    r_sum   <= SW'(w_pq) + SW'(r_integ);
                    r_a     <= OW'(w_vel) - OW'(r_prev_st[r_axis]);
                    r_state <= S_MDRV;
                end
                S_MDRV: r_state <= S_SUM;
                S_SUM: begin
                    r_a               <= w_sclmp[OW-1:0];
                    r_prev_st[r_axis] <= w_vel;
                    r_state           <= S_MMAS;
                end
                S_MMAS: r_state <= S_FRC;
                S_FRC: begin
                    r_force[r_axis] <= w_fclmp[DW-1:0];
                    if (r_axis == LAST_AXIS) begin
                        r_state <= S_DONE;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_ERR;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_ofx   <= r_force[0];
                        r_ofy   <= r_force[1];
                        r_ofz   <= r_force[2];
                        r_oact  <= r_act;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_force_x   = r_ofx;
    assign o_force_y   = r_ofy;
    assign o_force_z   = r_ofz;
    assign o_active    = r_oact;

    `CPVP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        w_accept, o_in_stall, "word accepted but input not stalled next cycle")

    `CPVP_ASSERT_SAME(a_disarmed_zero, i_clk, i_rst_n,
        o_out_valid && !o_active,
        (o_force_x == '0) && (o_force_y == '0) && (o_force_z == '0),
        "disarmed word carries nonzero force")

    `CPVP_ASSERT_SAME(a_axis_range, i_clk, i_rst_n,
        r_state != S_IDLE, r_axis <= LAST_AXIS,
        "axis counter beyond configured axes")

    `CPVP_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n,
        w_load, o_out_valid && (r_state == S_IDLE),
        "result hand-off did not raise output valid")

endmodule
